@@ rtl/array_list_engine_core_macros.svh @@
// Assertion macros used by the checker file.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication
`define ALE_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ale_checker: same-cycle implication violated");

// Next-cycle implication
`define ALE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ale_checker: next-cycle implication violated");

`endif

@@ rtl/ale_pkg.sv @@
`default_nettype none

package ale_pkg;

   // Field widths of the transaction payloads
   localparam int FUNC_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 6;
   localparam int INDEX_W     = 5;
   localparam int MAX_RESULTS = 32;

   // Operation codes; code 7 is a no-op
   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND       = 3'd0,
      FUNC_REMOVE_LAST  = 3'd1,
      FUNC_PREPEND      = 3'd2,
      FUNC_REMOVE_FIRST = 3'd3,
      FUNC_INSERT_AT    = 3'd4,
      FUNC_REMOVE_AT    = 3'd5,
      FUNC_SEARCH       = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_SEARCH = 1'b1
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;       // request transaction taken this cycle
      logic search_step;  // emit one search result this cycle
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;     // output register can load this cycle
      logic step_last;    // the search result being emitted is the final one
      logic is_search;    // pending request is a search
   } ctrl_status_type;

endpackage

`default_nettype wire

@@ rtl/ale_req_if.sv @@
`default_nettype none

interface ale_req_if;
   logic                              valid;
   logic                              ready;
   logic        [ale_pkg::FUNC_W-1:0] func;
   logic signed [ale_pkg::VALUE_W-1:0] value;
   logic        [ale_pkg::POS_W-1:0]  position;

   modport source (output valid, func, value, position, input ready);
   modport sink   (input valid, func, value, position, output ready);
endinterface

`default_nettype wire

@@ rtl/ale_rsp_if.sv @@
`default_nettype none

interface ale_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ale_pkg::STATUS_W-1:0]  status;
   logic [ale_pkg::COUNT_W-1:0]   count;
   logic                          found;
   logic [ale_pkg::INDEX_W-1:0]   match_index;
   logic                          last;

   modport source (output valid, status, count, found, match_index, last, input ready);
   modport sink   (input valid, status, count, found, match_index, last, output ready);
endinterface

`default_nettype wire

@@ rtl/ale_ctrl.sv @@
`default_nettype none

module ale_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ale_pkg::ctrl_status_type sts,
   output ale_pkg::ctrl_cmd_type    cmd
);

   ale_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ale_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.accept      = 1'b0;
      cmd.search_step = 1'b0;
      case (state_ff)
         ale_pkg::ST_IDLE: begin
            // take a request once the output register can hold its result
            req_ready  = sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept && sts.is_search) begin
               state_in = ale_pkg::ST_SEARCH;
            end
         end
         ale_pkg::ST_SEARCH: begin
            // one result per free output slot until the final one
            cmd.search_step = sts.out_free;
            if (sts.out_free && sts.step_last) begin
               state_in = ale_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ale_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/ale_datapath.sv @@
`default_nettype none

module ale_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ale_pkg::ctrl_cmd_type                cmd,
   output ale_pkg::ctrl_status_type             sts,
   input  logic        [ale_pkg::FUNC_W-1:0]    req_func,
   input  logic signed [ale_pkg::VALUE_W-1:0]   req_value,
   input  logic        [ale_pkg::POS_W-1:0]     req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic        [ale_pkg::STATUS_W-1:0]  rsp_status,
   output logic        [ale_pkg::COUNT_W-1:0]   rsp_count,
   output logic                                 rsp_found,
   output logic        [ale_pkg::INDEX_W-1:0]   rsp_match_index,
   output logic                                 rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W + 1 > ale_pkg::POS_W) ? CNT_W + 1 : ale_pkg::POS_W;
   localparam int RES_W = $clog2(ale_pkg::MAX_RESULTS);

   // Shift cells, count and search state
   logic signed [ale_pkg::VALUE_W-1:0] entry_ff [CAPACITY];
   logic signed [ale_pkg::VALUE_W-1:0] entry_in [CAPACITY];
   logic        [CNT_W-1:0]            count_ff, count_in;
   logic        [CAPACITY-1:0]         match_ff, match_in;
   logic        [RES_W-1:0]            nres_ff, nres_in;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in;
   ale_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic        [ale_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic        [ale_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                               rsp_last_ff, rsp_last_in;

   ale_pkg::status_type upd_status;
   logic                do_ins, do_rem, is_full, is_empty, is_search;
   logic [IDX_W-1:0]    slot;
   logic [CMP_W-1:0]    pos_ext, count_ext;
   logic [CAPACITY-1:0] hit, low_bit, rest;
   logic [IDX_W-1:0]    low_idx;
   logic                any_hit, step_last, load_upd;

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);
   assign is_search = (req_func == ale_pkg::FUNC_SEARCH);
   assign load_upd  = cmd.accept && !is_search;

   // Decode the update: status, shift direction and the slot it starts at
   always_comb begin
      upd_status = ale_pkg::STATUS_OK;
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      slot       = '0;
      case (req_func)
         ale_pkg::FUNC_APPEND: begin
            if (is_full) begin
               upd_status = ale_pkg::STATUS_FULL;
            end else begin
               do_ins = 1'b1;
               slot   = IDX_W'(count_ff);
            end
         end
         ale_pkg::FUNC_PREPEND: begin
            if (is_full) begin
               upd_status = ale_pkg::STATUS_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ale_pkg::FUNC_INSERT_AT: begin
            if (is_full) begin
               upd_status = ale_pkg::STATUS_FULL;
            end else if (pos_ext == '0 || pos_ext > count_ext + CMP_W'(1)) begin
               upd_status = ale_pkg::STATUS_RANGE;
            end else begin
               do_ins = 1'b1;
               slot   = IDX_W'(pos_ext - CMP_W'(1));
            end
         end
         ale_pkg::FUNC_REMOVE_LAST: begin
            if (is_empty) begin
               upd_status = ale_pkg::STATUS_EMPTY;
            end else begin
               do_rem = 1'b1;
               slot   = IDX_W'(count_ff - CNT_W'(1));
            end
         end
         ale_pkg::FUNC_REMOVE_FIRST: begin
            if (is_empty) begin
               upd_status = ale_pkg::STATUS_EMPTY;
            end else begin
               do_rem = 1'b1;
            end
         end
         ale_pkg::FUNC_REMOVE_AT: begin
            if (is_empty) begin
               upd_status = ale_pkg::STATUS_EMPTY;
            end else if (pos_ext == '0 || pos_ext > count_ext) begin
               upd_status = ale_pkg::STATUS_RANGE;
            end else begin
               do_rem = 1'b1;
               slot   = IDX_W'(pos_ext - CMP_W'(1));
            end
         end
         default: begin
            // search and the unused code leave the list alone
            upd_status = ale_pkg::STATUS_OK;
         end
      endcase
   end

   // Each cell keeps, takes the new word, or takes its lower or upper neighbor
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entry_in[i] = entry_ff[i];
         if (do_ins && IDX_W'(i) == slot) begin
            entry_in[i] = req_value;
         end else if (do_ins && IDX_W'(i) > slot) begin
            entry_in[i] = entry_ff[(i > 0) ? i - 1 : 0];
         end else if (do_rem && IDX_W'(i) >= slot) begin
            entry_in[i] = entry_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (load_upd && do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (load_upd && do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Parallel compare against all held entries
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i] = (entry_ff[i] == req_value) && (CNT_W'(i) < count_ff);
      end
   end

   // Lowest pending match and its index
   assign low_bit = match_ff & (~match_ff + CAPACITY'(1));
   assign rest    = match_ff & ~low_bit;
   assign any_hit = |match_ff;

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | IDX_W'(i);
         end
      end
   end

   assign step_last = !any_hit || (rest == '0) ||
                      (nres_ff == RES_W'(ale_pkg::MAX_RESULTS - 1));

   always_comb begin
      match_in = match_ff;
      nres_in  = nres_ff;
      if (cmd.accept && is_search) begin
         match_in = hit;
         nres_in  = '0;
      end else if (cmd.search_step) begin
         match_in = rest;
         nres_in  = nres_ff + RES_W'(1);
      end
   end

   // Output register load
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (load_upd) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = upd_status;
         rsp_count_in  = ale_pkg::COUNT_W'(count_in);
         rsp_found_in  = 1'b0;
         rsp_index_in  = '0;
         rsp_last_in   = 1'b1;
      end else if (cmd.search_step) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ale_pkg::STATUS_OK;
         rsp_count_in  = ale_pkg::COUNT_W'(count_ff);
         rsp_found_in  = any_hit;
         rsp_index_in  = any_hit ? ale_pkg::INDEX_W'(low_idx) : '0;
         rsp_last_in   = step_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_upd && (do_ins || do_rem)) begin
         entry_ff <= entry_in;
      end
      match_ff      <= match_in;
      nres_ff       <= nres_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign sts.step_last   = step_last;
   assign sts.is_search   = is_search;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/array_list_engine_core.sv @@
// Update requests: result is valid in the cycle after the request transaction; a new
// request is taken every cycle while the output register is free or being drained.
// Search: the match vector is captured at acceptance, then one result per cycle is
// emitted from the output register while it is free or being drained (1 to 32
// results); no request is taken meanwhile. Reset (synchronous, active high) empties
// the list and clears the controller and output valid; entry storage is not cleared.
`default_nettype none

module array_list_engine_core #(
   parameter int CAPACITY = 32
) (
   input  logic      clock,
   input  logic      reset,
   ale_req_if.sink   req_chan,
   ale_rsp_if.source rsp_chan
);

   ale_pkg::ctrl_cmd_type    cmd;
   ale_pkg::ctrl_status_type sts;

   ale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ale_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_chan.func),
      .req_value       (req_chan.value),
      .req_position    (req_chan.position),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_count       (rsp_chan.count),
      .rsp_found       (rsp_chan.found),
      .rsp_match_index (rsp_chan.match_index),
      .rsp_last        (rsp_chan.last)
   );

endmodule

`default_nettype wire

@@ rtl/ale_checker.sv @@
`default_nettype none

`include "array_list_engine_core_macros.svh"

module ale_checker #(
   parameter int CAPACITY = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ale_pkg::STATUS_W-1:0] rsp_status,
   input logic [ale_pkg::COUNT_W-1:0]  rsp_count,
   input logic                         rsp_found,
   input logic [ale_pkg::INDEX_W-1:0]  rsp_match_index,
   input logic                         rsp_last
);

   localparam int PAYLOAD_W = ale_pkg::STATUS_W + ale_pkg::COUNT_W + ale_pkg::INDEX_W + 2;

   // Whole result payload, for the hold check
   logic [PAYLOAD_W-1:0] rsp_payload;

   assign rsp_payload = {rsp_status, rsp_count, rsp_found, rsp_match_index, rsp_last};

   // A stalled result transaction keeps its payload
   `ALE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Only search matches can be followed by more results of the same request
   `ALE_ASSERT_IMPL(a_nonlast_is_match, rsp_valid && !rsp_last, rsp_found && rsp_status == ale_pkg::STATUS_OK)

   // A result without a match carries index zero
   `ALE_ASSERT_IMPL(a_nomatch_index, rsp_valid && !rsp_found, rsp_match_index == '0)

   // Reported count never exceeds the capacity
   `ALE_ASSERT_IMPL(a_count_bound, rsp_valid, 32'(rsp_count) <= 32'(CAPACITY))

endmodule

bind array_list_engine_core ale_checker #(
   .CAPACITY (CAPACITY)
) u_ale_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_count       (rsp_chan.count),
   .rsp_found       (rsp_chan.found),
   .rsp_match_index (rsp_chan.match_index),
   .rsp_last        (rsp_chan.last)
);

`default_nettype wire
